### hdl/cfrr_pkg.sv
package cfrr_pkg;

	localparam int MAX_STRINGS_DEF = 32;

	localparam int SYM_W    = 8;
	localparam int ROW_W    = 5;
	localparam int LETTER_W = 7;
	localparam int DIST_W   = 6;
	localparam int NS_W     = 6;

	localparam logic [NS_W-1:0]     NS_RESET    = 6'd2;
	localparam logic [LETTER_W-1:0] LETTER_BASE = 7'd65;

	// Strobes from the sequencer to every rank cell.
	typedef struct packed {
		logic clear;
		logic load;
		logic rank;
	} cell_ctl_t;

	// Strobes to the result chain.
	typedef struct packed {
		logic load;
		logic shift;
	} emit_ctl_t;

endpackage

### hdl/cfrr_rank_cell.sv
module cfrr_rank_cell import cfrr_pkg::*; #(
	parameter int CNT_W = 6,
	parameter int IDX_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic             wr_sel,
	input  logic             shift_en,
	input  logic [SYM_W-1:0] in_sym,
	input  logic             in_any,
	input  logic [CNT_W-1:0] in_cnt,
	input  logic [IDX_W-1:0] in_first_row,
	input  logic [IDX_W-1:0] wr_row,
	input  logic [CNT_W-1:0] probe_cnt,
	input  logic             probe_first,
	input  logic [IDX_W-1:0] probe_row,
	input  logic [SYM_W-1:0] sh_sym,
	input  logic [CNT_W-1:0] sh_cnt,
	input  logic [IDX_W-1:0] sh_first_row,
	input  logic             sh_first,
	input  logic [IDX_W-1:0] sh_rank,
	output logic             match,
	output logic [SYM_W-1:0] sym,
	output logic [CNT_W-1:0] cnt,
	output logic [IDX_W-1:0] first_row,
	output logic             first,
	output logic [IDX_W-1:0] rank,
	output logic [IDX_W-1:0] nxt_rank
);

	logic             valid_q;
	logic [SYM_W-1:0] sym_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] first_row_q;
	logic             first_q;
	logic [IDX_W-1:0] rank_q;
	logic             beaten;

	assign match = valid_q && (sym_q == in_sym);

	// The probe outranks this symbol: higher count, or equal count and seen earlier.
	assign beaten = probe_first && (probe_row != first_row_q) &&
		((probe_cnt > cnt_q) || ((probe_cnt == cnt_q) && (probe_row < first_row_q)));

	assign nxt_rank = rank_q + IDX_W'(beaten);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.load && wr_sel) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (wr_sel) begin
				sym_q       <= in_sym;
				cnt_q       <= in_any ? in_cnt + CNT_W'(1) : CNT_W'(1);
				first_row_q <= in_any ? in_first_row : wr_row;
				first_q     <= !in_any;
				rank_q      <= '0;
			end else if (match) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end else if (ctl.rank && shift_en) begin
			// advance one place around the ring
			sym_q       <= sh_sym;
			cnt_q       <= sh_cnt;
			first_row_q <= sh_first_row;
			first_q     <= sh_first;
			rank_q      <= sh_rank;
		end
	end

	assign sym       = sym_q;
	assign cnt       = cnt_q;
	assign first_row = first_row_q;
	assign first     = first_q;
	assign rank      = rank_q;

endmodule

### hdl/cfrr_emit_cell.sv
module cfrr_emit_cell import cfrr_pkg::*; #(
	parameter int RANK_W = 5
) (
	input  logic                clk,
	input  emit_ctl_t           ctl,
	input  logic [SYM_W-1:0]    ld_sym,
	input  logic [RANK_W-1:0]   ld_rank,
	input  logic [SYM_W-1:0]    sh_sym,
	input  logic [LETTER_W-1:0] sh_letter,
	output logic [SYM_W-1:0]    sym,
	output logic [LETTER_W-1:0] letter
);

	logic [SYM_W-1:0]    sym_q;
	logic [LETTER_W-1:0] letter_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sym_q    <= ld_sym;
			letter_q <= LETTER_BASE + LETTER_W'(ld_rank);
		end else if (ctl.shift) begin
			sym_q    <= sh_sym;
			letter_q <= sh_letter;
		end
	end

	assign sym    = sym_q;
	assign letter = letter_q;

endmodule

### hdl/column_frequency_rank_remap.sv
// Column frequency rank remap.
// Configuration: write num_strings on the cfg channel (cfg_ready is always high) only while
// the block is idle; a write drops any partly loaded column. Values below 2 act as 2, values
// above MAX_STRINGS act as MAX_STRINGS.
// Input: one symbol per request on in_valid/in_ready, one per cycle while loading. Each symbol
// is compared against all loaded rows at once to keep per-symbol counts.
// After the n-th symbol the row of rank cells rotates n times, one cell a cycle, so every
// cell sees every distinct symbol's count; then the ranks are handed to the result chain
// once that chain is empty.
// Output: n requests on out_valid/out_ready, rows in input order, last on the final row.
// The result chain shifts one row per accepted request and is separate from the rank cells,
// so the next column loads and ranks while results drain. in_ready is low during rotation
// and hand-off.
// If the receiver stalls, the current result holds; a finished column waits in the rank
// cells until the result chain is empty.
// Reset: num_strings returns to 2, the column is empty and no results are pending.
module column_frequency_rank_remap import cfrr_pkg::*; #(
	parameter int MAX_STRINGS = MAX_STRINGS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [NS_W-1:0]     num_strings,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SYM_W-1:0]    symbol,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ROW_W-1:0]    row_index,
	output logic [SYM_W-1:0]    original_symbol,
	output logic [LETTER_W-1:0] rank_letter,
	output logic [DIST_W-1:0]   distinct_count,
	output logic                last
);

	localparam int NW = $clog2(MAX_STRINGS + 1);
	localparam int IW = $clog2(MAX_STRINGS);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_RANK = 3'b010,
		ST_HAND = 3'b100
	} phase_t;

	phase_t              state_q;
	logic [NS_W-1:0]     ns_q;
	logic [NW-1:0]       fill_q;
	logic [NW-1:0]       distinct_q;
	logic [IW-1:0]       probe_q;
	logic [NW-1:0]       out_left_q;
	logic [ROW_W-1:0]    out_row_q;
	logic [DIST_W-1:0]   out_dist_q;

	logic [NW-1:0]       n_eff;
	logic [NW-1:0]       n_last;
	logic                cfg_wr;
	logic                load_fire;
	logic                xfer;
	logic                pop;
	cell_ctl_t           cctl;
	emit_ctl_t           ectl;

	logic                c_match     [MAX_STRINGS];
	logic [SYM_W-1:0]    c_sym       [MAX_STRINGS];
	logic [NW-1:0]       c_cnt       [MAX_STRINGS];
	logic [IW-1:0]       c_first_row [MAX_STRINGS];
	logic                c_first     [MAX_STRINGS];
	logic [IW-1:0]       c_rank      [MAX_STRINGS];
	logic [IW-1:0]       c_nxt_rank  [MAX_STRINGS];
	logic [SYM_W-1:0]    e_sym       [MAX_STRINGS];
	logic [LETTER_W-1:0] e_letter    [MAX_STRINGS];

	logic                any_match;
	logic [NW-1:0]       match_cnt;
	logic [IW-1:0]       match_row;

	always_comb begin
		if (ns_q < NS_W'(2)) begin
			n_eff = NW'(2);
		end else if (int'(ns_q) > MAX_STRINGS) begin
			n_eff = NW'(MAX_STRINGS);
		end else begin
			n_eff = NW'(ns_q);
		end
	end

	assign n_last = n_eff - NW'(1);

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign in_ready  = (state_q == ST_LOAD);
	assign load_fire = in_valid && in_ready;
	assign out_valid = (out_left_q != '0);
	assign pop       = out_valid && out_ready;
	assign xfer      = (state_q == ST_HAND) && (out_left_q == '0);

	assign cctl.clear = cfg_wr || xfer;
	assign cctl.load  = load_fire;
	assign cctl.rank  = (state_q == ST_RANK);
	assign ectl.load  = xfer;
	assign ectl.shift = pop;

	// All rows of one symbol hold the same count and first row, so OR picks them out.
	always_comb begin
		any_match = 1'b0;
		match_cnt = '0;
		match_row = '0;
		for (int i = 0; i < MAX_STRINGS; i++) begin
			any_match = any_match | c_match[i];
			match_cnt = match_cnt | (c_match[i] ? c_cnt[i] : '0);
			match_row = match_row | (c_match[i] ? c_first_row[i] : '0);
		end
	end

	for (genvar i = 0; i < MAX_STRINGS; i++) begin : g_cell
		logic [SYM_W-1:0]    sh_sym;
		logic [NW-1:0]       sh_cnt;
		logic [IW-1:0]       sh_first_row;
		logic                sh_first;
		logic [IW-1:0]       sh_rank;
		logic [SYM_W-1:0]    esh_sym;
		logic [LETTER_W-1:0] esh_letter;

		if (i < MAX_STRINGS - 1) begin : g_mid
			logic wrap;
			assign wrap         = (NW'(i) == n_last);
			assign sh_sym       = wrap ? c_sym[0]       : c_sym[i+1];
			assign sh_cnt       = wrap ? c_cnt[0]       : c_cnt[i+1];
			assign sh_first_row = wrap ? c_first_row[0] : c_first_row[i+1];
			assign sh_first     = wrap ? c_first[0]     : c_first[i+1];
			assign sh_rank      = wrap ? c_nxt_rank[0]  : c_nxt_rank[i+1];
			assign esh_sym      = e_sym[i+1];
			assign esh_letter   = e_letter[i+1];
		end else begin : g_end
			assign sh_sym       = c_sym[0];
			assign sh_cnt       = c_cnt[0];
			assign sh_first_row = c_first_row[0];
			assign sh_first     = c_first[0];
			assign sh_rank      = c_nxt_rank[0];
			assign esh_sym      = e_sym[i];
			assign esh_letter   = e_letter[i];
		end

		cfrr_rank_cell #(
			.CNT_W (NW),
			.IDX_W (IW)
		) u_rank (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (cctl),
			.wr_sel       (fill_q == NW'(i)),
			.shift_en     (NW'(i) < n_eff),
			.in_sym       (symbol),
			.in_any       (any_match),
			.in_cnt       (match_cnt),
			.in_first_row (match_row),
			.wr_row       (fill_q[IW-1:0]),
			.probe_cnt    (c_cnt[0]),
			.probe_first  (c_first[0]),
			.probe_row    (probe_q),
			.sh_sym       (sh_sym),
			.sh_cnt       (sh_cnt),
			.sh_first_row (sh_first_row),
			.sh_first     (sh_first),
			.sh_rank      (sh_rank),
			.match        (c_match[i]),
			.sym          (c_sym[i]),
			.cnt          (c_cnt[i]),
			.first_row    (c_first_row[i]),
			.first        (c_first[i]),
			.rank         (c_rank[i]),
			.nxt_rank     (c_nxt_rank[i])
		);

		cfrr_emit_cell #(
			.RANK_W (IW)
		) u_emit (
			.clk       (clk),
			.ctl       (ectl),
			.ld_sym    (c_sym[i]),
			.ld_rank   (c_rank[i]),
			.sh_sym    (esh_sym),
			.sh_letter (esh_letter),
			.sym       (e_sym[i]),
			.letter    (e_letter[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			ns_q       <= NS_RESET;
			fill_q     <= '0;
			distinct_q <= '0;
			probe_q    <= '0;
		end else if (cfg_wr) begin
			ns_q       <= num_strings;
			state_q    <= ST_LOAD;
			fill_q     <= '0;
			distinct_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (load_fire) begin
						fill_q <= fill_q + NW'(1);
						if (!any_match) begin
							distinct_q <= distinct_q + NW'(1);
						end
						if (fill_q + NW'(1) == n_eff) begin
							state_q <= ST_RANK;
							probe_q <= '0;
						end
					end
				end
				ST_RANK: begin
					probe_q <= probe_q + IW'(1);
					if (NW'(probe_q) == n_last) begin
						state_q <= ST_HAND;
					end
				end
				ST_HAND: begin
					// hold until the result chain has drained
					if (xfer) begin
						state_q    <= ST_LOAD;
						fill_q     <= '0;
						distinct_q <= '0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_left_q <= '0;
			out_row_q  <= '0;
			out_dist_q <= '0;
		end else if (xfer) begin
			out_left_q <= n_eff;
			out_row_q  <= '0;
			out_dist_q <= DIST_W'(distinct_q);
		end else if (pop) begin
			out_left_q <= out_left_q - NW'(1);
			out_row_q  <= out_row_q + ROW_W'(1);
		end
	end

	assign row_index       = out_row_q;
	assign original_symbol = e_sym[0];
	assign rank_letter     = e_letter[0];
	assign distinct_count  = out_dist_q;
	assign last            = (out_left_q == NW'(1));

endmodule

### hdl/cfrr_checker.sv
module cfrr_checker import cfrr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [ROW_W-1:0]    row_index,
	input logic [SYM_W-1:0]    original_symbol,
	input logic [LETTER_W-1:0] rank_letter,
	input logic [DIST_W-1:0]   distinct_count,
	input logic                last
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(original_symbol) &&
			$stable(rank_letter) && $stable(row_index) && $stable(last) &&
			$stable(distinct_count))
		else $error("result changed while stalled");

	// Rows of a column come out in order.
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid &&
			(row_index == $past(row_index) + ROW_W'(1)))
		else $error("row index did not advance by one");

	// A new column starts at row zero.
	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> row_index == '0)
		else $error("new column did not start at row zero");

	// A register write leaves the block ready for symbols.
	a_cfg_load: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_ready)
		else $error("not accepting symbols after register write");

endmodule

bind column_frequency_rank_remap cfrr_checker u_cfrr_checker (.*);

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cfrr_pkg::*;

	localparam int MAX_ROWS    = MAX_STRINGS_DEF;
	localparam int SETTLE      = 2 * MAX_ROWS + 8;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic {STEP_CFG, STEP_SYM} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		logic [7:0]          value;
		logic [LETTER_W-1:0] letter;
		logic [DIST_W-1:0]   ndistinct;
	} plan_step_t;

	typedef struct packed {
		logic [ROW_W-1:0]    row;
		logic [SYM_W-1:0]    sym;
		logic [LETTER_W-1:0] letter;
		logic [DIST_W-1:0]   ndistinct;
		logic                last;
	} row_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [NS_W-1:0]     num_strings = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SYM_W-1:0]    symbol = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ROW_W-1:0]    row_index;
	logic [SYM_W-1:0]    original_symbol;
	logic [LETTER_W-1:0] rank_letter;
	logic [DIST_W-1:0]   distinct_count;
	logic                last;

	column_frequency_rank_remap i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.num_strings     (num_strings),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.symbol          (symbol),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.row_index       (row_index),
		.original_symbol (original_symbol),
		.rank_letter     (rank_letter),
		.distinct_count  (distinct_count),
		.last            (last)
	);

	always #1 clk = ~clk;

	// Column shadow state
	logic [NS_W-1:0]     column_setting = NS_RESET;
	logic [SYM_W-1:0]    column_syms [MAX_ROWS];
	int unsigned         row_counts [MAX_ROWS];
	int unsigned         fill_rows = 0;
	logic [LETTER_W-1:0] pin_letter [MAX_ROWS];
	logic [DIST_W-1:0]   pin_dist [MAX_ROWS];

	row_result_t due_rows [$];
	int          mismatches = 0;
	int          idle_in_pct = 0;
	int          idle_out_pct = 0;
	int          idle_cycles = 0;

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic int unsigned column_size();
		if (column_setting < 2)
			return 2;
		if (column_setting > MAX_ROWS)
			return MAX_ROWS;
		return column_setting;
	endfunction

	function automatic int unsigned first_seen(input int unsigned r);
		for (int unsigned j = 0; j < r; j++)
			if (column_syms[j] == column_syms[r])
				return j;
		return r;
	endfunction

	function automatic void drop_column();
		fill_rows = 0;
		for (int k = 0; k < MAX_ROWS; k++) begin
			row_counts[k] = 0;
			pin_letter[k] = '0;
			pin_dist[k] = '0;
		end
	endfunction

	// Load one symbol; on the column's last one, queue a result per row.
	task automatic rank_column(input logic [SYM_W-1:0] s);
		int unsigned n, pos, f, c, rank, distinct;
		row_result_t res;
		n = column_size();
		pos = fill_rows;
		column_syms[pos] = s;
		row_counts[pos] = 0;
		row_counts[first_seen(pos)]++;
		fill_rows = pos + 1;
		if (fill_rows >= n) begin
			distinct = 0;
			for (int unsigned r = 0; r < n; r++)
				if (row_counts[r] != 0)
					distinct++;
			for (int unsigned r = 0; r < n; r++) begin
				f = first_seen(r);
				c = row_counts[f];
				rank = 0;
				for (int unsigned e = 0; e < n; e++) begin
					if (row_counts[e] != 0 && e != f &&
					    (row_counts[e] > c || (row_counts[e] == c && e < f)))
						rank++;
				end
				res.row = r[ROW_W-1:0];
				res.sym = column_syms[r];
				res.letter = LETTER_BASE + rank[LETTER_W-1:0];
				res.ndistinct = distinct[DIST_W-1:0];
				res.last = (r + 1 == n);
				if (pin_letter[r] != '0) begin
					res.letter = pin_letter[r];
					res.ndistinct = pin_dist[r];
				end
				due_rows.push_back(res);
			end
			drop_column();
		end
	endtask

	task automatic send_symbol(input logic [SYM_W-1:0] s);
		while ($urandom_range(0, 99) < idle_in_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		symbol <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		rank_column(s);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (due_rows.size() != 0)
			@(posedge clk);
	endtask

	// Write only once all results are out and ranking has settled.
	task automatic set_column_size(input logic [NS_W-1:0] v);
		hold_until_drained();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		num_strings <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		column_setting = v;
		drop_column();
	endtask

	always @(posedge clk) begin
		row_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_rows.size() == 0) begin
				flag_mismatch("unrequested row", row_index, -1);
			end else begin
				want = due_rows.pop_front();
				if (row_index !== want.row)
					flag_mismatch("row_index", row_index, want.row);
				if (original_symbol !== want.sym)
					flag_mismatch("original_symbol", original_symbol, want.sym);
				if (rank_letter !== want.letter)
					flag_mismatch("rank_letter", rank_letter, want.letter);
				if (distinct_count !== want.ndistinct)
					flag_mismatch("distinct_count", distinct_count, want.ndistinct);
				if (last !== want.last)
					flag_mismatch("last", last, want.last);
			end
		end
		out_ready <= arst_n && ($urandom_range(0, 99) >= idle_out_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	plan_step_t plan [27] = '{
		'{STEP_SYM, 8'h00, LETTER_BASE,         6'd2},
		'{STEP_SYM, 8'hFF, LETTER_BASE + 7'd1,  6'd2},
		'{STEP_SYM, 8'h41, LETTER_BASE,         6'd1},
		'{STEP_SYM, 8'h41, LETTER_BASE,         6'd1},
		'{STEP_CFG, 8'd3,  7'd0,                6'd0},
		'{STEP_SYM, 8'h07, 7'd0,                6'd0},
		'{STEP_CFG, 8'd0,  7'd0,                6'd0},
		'{STEP_SYM, 8'h80, LETTER_BASE,         6'd2},
		'{STEP_SYM, 8'h01, LETTER_BASE + 7'd1,  6'd2},
		'{STEP_CFG, 8'd1,  7'd0,                6'd0},
		'{STEP_SYM, 8'h05, LETTER_BASE,         6'd1},
		'{STEP_SYM, 8'h05, LETTER_BASE,         6'd1},
		'{STEP_CFG, 8'd4,  7'd0,                6'd0},
		'{STEP_SYM, 8'h01, LETTER_BASE + 7'd1,  6'd3},
		'{STEP_SYM, 8'h02, LETTER_BASE,         6'd3},
		'{STEP_SYM, 8'h02, LETTER_BASE,         6'd3},
		'{STEP_SYM, 8'h03, LETTER_BASE + 7'd2,  6'd3},
		'{STEP_CFG, 8'd5,  7'd0,                6'd0},
		'{STEP_SYM, 8'hAA, LETTER_BASE,         6'd3},
		'{STEP_SYM, 8'h55, LETTER_BASE + 7'd1,  6'd3},
		'{STEP_SYM, 8'h55, LETTER_BASE + 7'd1,  6'd3},
		'{STEP_SYM, 8'hAA, LETTER_BASE,         6'd3},
		'{STEP_SYM, 8'h00, LETTER_BASE + 7'd2,  6'd3},
		'{STEP_CFG, 8'd3,  7'd0,                6'd0},
		'{STEP_SYM, 8'h09, LETTER_BASE,         6'd1},
		'{STEP_SYM, 8'h09, LETTER_BASE,         6'd1},
		'{STEP_SYM, 8'h09, LETTER_BASE,         6'd1}
	};

	logic [NS_W-1:0] phase_sizes [9] = '{6'd2, 6'd32, 6'd0, 6'd13, 6'd63, 6'd1, 6'd7, 6'd33, 6'd2};

	initial begin
		int unsigned     n, count, row, style, pal_size;
		logic [SYM_W-1:0] base, s;
		logic [SYM_W-1:0] palette [8];
		logic [NS_W-1:0]  size;

		drop_column();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_in_pct = 7;
		idle_out_pct = 45;
		foreach (plan[k]) begin
			if (plan[k].kind == STEP_CFG) begin
				set_column_size(plan[k].value[NS_W-1:0]);
			end else begin
				pin_letter[fill_rows] = plan[k].letter;
				pin_dist[fill_rows] = plan[k].ndistinct;
				send_symbol(plan[k].value);
			end
		end

		for (int p = 0; p < 9; p++) begin
			idle_in_pct = (p < 3) ? 7 : (p < 6) ? 45 : 0;
			idle_out_pct = (p < 3) ? 45 : (p < 6) ? 7 : 0;
			size = (p == 8) ? NS_W'($urandom_range(3, 31)) : phase_sizes[p];
			set_column_size(size);
			n = column_size();
			count = ((30 + n - 1) / n) * n;
			// leave a partial column now and then for the next write to drop
			if ($urandom_range(0, 2) == 0)
				count += $urandom_range(1, n - 1);
			for (int unsigned i = 0; i < count; i++) begin
				if (i == count / 2)
					hold_until_drained();
				row = i % n;
				if (row == 0) begin
					style = $urandom_range(0, 3);
					base = SYM_W'($urandom_range(0, 255));
					pal_size = $urandom_range(1, 8);
					foreach (palette[k])
						palette[k] = SYM_W'($urandom_range(0, 255));
				end
				case (style)
					0: s = base + row[SYM_W-1:0];
					1: s = palette[$urandom_range(0, pal_size - 1)];
					2: s = base;
					default: s = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 2)]
					                                         : SYM_W'($urandom_range(0, 255));
				endcase
				send_symbol(s);
			end
		end

		hold_until_drained();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### column_frequency_rank_remap.f
hdl/cfrr_pkg.sv
hdl/cfrr_rank_cell.sv
hdl/cfrr_emit_cell.sv
hdl/column_frequency_rank_remap.sv
hdl/cfrr_checker.sv
bench/testbench.sv
